// ===== rtl/rgsg_pkg.sv =====
// Shared types and constants for the regular grid sample generator.
package rgsg_pkg;

	typedef enum logic [2:0] {
		REG_X_RESOLUTION = 3'd0,
		REG_SAMPLES_X    = 3'd1,
		REG_SAMPLES_Y    = 3'd2,
		REG_X_FRACTION   = 3'd3,
		REG_Y_FRACTION   = 3'd4,
		REG_X_SCALE      = 3'd5,
		REG_Y_SCALE      = 3'd6
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned RES_W      = 13;
	localparam int unsigned COUNT_W    = 4;
	localparam int unsigned FRAC_W     = 17;
	localparam int unsigned SCALE_W    = 32;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned SIDX_W     = 6;
	localparam int unsigned PIDX_W     = 24;
	localparam int unsigned FRAC_SHIFT = 16;

	localparam logic [FRAC_SHIFT-1:0] ROUND_HALF = 16'h8000;
	localparam logic [POS_W-1:0]      POS_MAX    = 32'h7fff_ffff;
	localparam logic [POS_W-1:0]      POS_ONE    = 32'h4000_0000;
	localparam logic [63:0]           SAT_LIMIT  = 64'd3221225472;

	localparam logic [RES_W-1:0]   RST_X_RESOLUTION = 13'd512;
	localparam logic [COUNT_W-1:0] RST_SAMPLES      = 4'd2;
	localparam logic [FRAC_W-1:0]  RST_FRACTION     = 17'd32768;
	localparam logic [SCALE_W-1:0] RST_SCALE        = 32'd4194304;

endpackage

// ===== rtl/rgsg_front.sv =====
// Front end: accepts pixel transactions, forms the linear pixel id and queues them.
module rgsg_front import rgsg_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic [RES_W-1:0]      x_resolution,
	output logic                  item_valid,
	input  logic                  item_pop,
	output logic [COORD_BITS-1:0] item_px,
	output logic [COORD_BITS-1:0] item_py,
	output logic [PIDX_W-1:0]     item_pid
);

	localparam int PF_W = (COORD_BITS + RES_W > PIDX_W) ? COORD_BITS + RES_W : PIDX_W;

	logic [COORD_BITS-1:0] px_q [2];
	logic [COORD_BITS-1:0] py_q [2];
	logic [PIDX_W-1:0]     pid_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  push;
	logic [PF_W-1:0]       pid_full;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign pid_full = PF_W'(pixel_y) * PF_W'(x_resolution) + PF_W'(pixel_x);

	assign item_valid = (count_q != 2'd0);
	assign item_px    = px_q[rd_ptr_q];
	assign item_py    = py_q[rd_ptr_q];
	assign item_pid   = pid_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			px_q[wr_ptr_q]  <= pixel_x;
			py_q[wr_ptr_q]  <= pixel_y;
			pid_q[wr_ptr_q] <= pid_full[PIDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !item_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && item_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/rgsg_axis.sv =====
// One axis of the position datapath: scale multiply, rounding and saturation.
module rgsg_axis import rgsg_pkg::*; #(
	parameter int U_W = 29
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [U_W-1:0]          u,
	input  logic [SCALE_W-1:0]      scale,
	output logic signed [POS_W-1:0] pos
);

	localparam int PROD_W = U_W + SCALE_W;
	localparam int R_W    = PROD_W + 1 - FRAC_SHIFT;

	logic [PROD_W-1:0]       prod_s1;
	logic [PROD_W:0]         rnd;
	logic [R_W-1:0]          r;
	logic                    sat;
	logic [POS_W-1:0]        pos_next;
	logic signed [POS_W-1:0] pos_s2;

	assign rnd      = {1'b0, prod_s1} + (PROD_W + 1)'(ROUND_HALF);
	assign r        = rnd[PROD_W:FRAC_SHIFT];
	assign sat      = (r >= R_W'(SAT_LIMIT));
	assign pos_next = sat ? POS_MAX : (r[POS_W-1:0] - POS_ONE);
	assign pos      = pos_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(u) * PROD_W'(scale);
			pos_s2  <= signed'(pos_next);
		end
	end

endmodule

// ===== rtl/rgsg_back.sv =====
// Back end: walks the sample grid of each queued pixel and drives the result pipeline.
module rgsg_back import rgsg_pkg::*; #(
	parameter int COORD_BITS    = 12,
	parameter int MAX_GRID_SIDE = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_pop,
	input  logic [COORD_BITS-1:0]   item_px,
	input  logic [COORD_BITS-1:0]   item_py,
	input  logic [PIDX_W-1:0]       item_pid,
	input  logic [COUNT_W-1:0]      samples_x,
	input  logic [COUNT_W-1:0]      samples_y,
	input  logic [FRAC_W-1:0]       x_fraction,
	input  logic [FRAC_W-1:0]       y_fraction,
	input  logic [SCALE_W-1:0]      x_scale,
	input  logic [SCALE_W-1:0]      y_scale,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] screen_x,
	output logic signed [POS_W-1:0] screen_y,
	output logic [SIDX_W-1:0]       sample_number,
	output logic [PIDX_W-1:0]       pixel_index,
	output logic                    last_sample
);

	localparam int SIDE_MAX = (MAX_GRID_SIDE < 15) ? MAX_GRID_SIDE : 15;
	localparam int CNT_W    = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
	localparam int U_W      = COORD_BITS + FRAC_SHIFT + 1;

	function automatic logic [COUNT_W-1:0] side_m1(input logic [COUNT_W-1:0] n);
		if (n == '0) begin
			return '0;
		end else if (n > COUNT_W'(SIDE_MAX)) begin
			return COUNT_W'(SIDE_MAX - 1);
		end else begin
			return n - COUNT_W'(1);
		end
	endfunction

	logic               busy_q;
	logic [CNT_W-1:0]   xs_q;
	logic [CNT_W-1:0]   ys_q;
	logic [U_W-1:0]     ux_q;
	logic [U_W-1:0]     uy_q;
	logic [U_W-1:0]     uy_base_q;
	logic [PIDX_W-1:0]  pid_q;
	logic [SIDX_W-1:0]  sidx_q;
	logic               valid_s1;
	logic [SIDX_W-1:0]  sidx_s1;
	logic [PIDX_W-1:0]  pid_s1;
	logic               last_s1;
	logic               valid_s2;
	logic [SIDX_W-1:0]  sidx_s2;
	logic [PIDX_W-1:0]  pid_s2;
	logic               last_s2;
	logic               en;
	logic               xs_last;
	logic               ys_last;
	logic               grid_last;
	logic [COUNT_W-1:0] nx_m1;
	logic [COUNT_W-1:0] ny_m1;

	assign nx_m1     = side_m1(samples_x);
	assign ny_m1     = side_m1(samples_y);
	assign xs_last   = (COUNT_W'(xs_q) == nx_m1);
	assign ys_last   = (COUNT_W'(ys_q) == ny_m1);
	assign grid_last = xs_last && ys_last;
	assign en        = !valid_s2 || !out_stall;
	assign item_pop  = en && item_valid && (!busy_q || grid_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			xs_q     <= '0;
			ys_q     <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= busy_q;
			valid_s2 <= valid_s1;
			if (item_pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && grid_last) begin
				busy_q <= 1'b0;
			end
			if (!busy_q || grid_last) begin
				xs_q <= '0;
				ys_q <= '0;
			end else if (ys_last) begin
				xs_q <= xs_q + CNT_W'(1);
				ys_q <= '0;
			end else begin
				ys_q <= ys_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (item_pop) begin
				ux_q      <= U_W'({item_px, ROUND_HALF});
				uy_q      <= U_W'({item_py, ROUND_HALF});
				uy_base_q <= U_W'({item_py, ROUND_HALF});
				pid_q     <= item_pid;
				sidx_q    <= '0;
			end else if (busy_q) begin
				if (ys_last) begin
					uy_q <= uy_base_q;
					ux_q <= ux_q + U_W'(x_fraction);
				end else begin
					uy_q <= uy_q + U_W'(y_fraction);
				end
				sidx_q <= sidx_q + SIDX_W'(1);
			end
			sidx_s1 <= sidx_q;
			pid_s1  <= pid_q;
			last_s1 <= grid_last;
			sidx_s2 <= sidx_s1;
			pid_s2  <= pid_s1;
			last_s2 <= last_s1;
		end
	end

	rgsg_axis #(.U_W(U_W)) u_axis_x (
		.clk   (clk),
		.en    (en),
		.u     (ux_q),
		.scale (x_scale),
		.pos   (screen_x)
	);

	rgsg_axis #(.U_W(U_W)) u_axis_y (
		.clk   (clk),
		.en    (en),
		.u     (uy_q),
		.scale (y_scale),
		.pos   (screen_y)
	);

	assign out_valid     = valid_s2;
	assign sample_number = sidx_s2;
	assign pixel_index   = pid_s2;
	assign last_sample   = last_s2;

endmodule

// ===== rtl/regular_grid_sample_generator_top.sv =====
// Top level of the regular grid sample generator with its register file.
//
// Each input transaction carries one pixel coordinate (pixel_x, pixel_y). For it the
// block delivers samples_x * samples_y output transactions (clamped as below), one per
// sub-pixel sample, column index outer and row index inner, each with its screen
// position, sample index, linear pixel id and a last_sample mark on the final one.
// Registers are written over the cfg channel (cfg_ready is always high) and should
// only change while no pixel is in flight.
// Each side count is clamped to 1..min(MAX_GRID_SIDE, 15). A pixel accepted while idle
// is queued, loaded into the grid walker, and its samples pass the multiply stage and
// the rounding stage. The walker delivers one sample per cycle while out_stall is low;
// pixels queued behind follow without a gap, while one reaching an idle block waits for its load.
// A two-entry queue in front of the walker takes new pixels while samples are still
// being delivered; in_stall rises only when that queue is full.
// When the receiver raises out_stall, the walker and its two pipeline stages freeze
// and the held sample stays on the outputs unchanged.
// Reset empties the queue and the pipeline and loads the register defaults.
module regular_grid_sample_generator_top import rgsg_pkg::*; #(
	parameter int MAX_GRID_SIDE = 8,
	parameter int COORD_BITS    = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   pixel_x,
	input  logic [COORD_BITS-1:0]   pixel_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] screen_x,
	output logic signed [POS_W-1:0] screen_y,
	output logic [SIDX_W-1:0]       sample_number,
	output logic [PIDX_W-1:0]       pixel_index,
	output logic                    last_sample
);

	logic [RES_W-1:0]      x_resolution_q;
	logic [COUNT_W-1:0]    samples_x_q;
	logic [COUNT_W-1:0]    samples_y_q;
	logic [FRAC_W-1:0]     x_fraction_q;
	logic [FRAC_W-1:0]     y_fraction_q;
	logic [SCALE_W-1:0]    x_scale_q;
	logic [SCALE_W-1:0]    y_scale_q;
	logic                  item_valid;
	logic                  item_pop;
	logic [COORD_BITS-1:0] item_px;
	logic [COORD_BITS-1:0] item_py;
	logic [PIDX_W-1:0]     item_pid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_resolution_q <= RST_X_RESOLUTION;
			samples_x_q    <= RST_SAMPLES;
			samples_y_q    <= RST_SAMPLES;
			x_fraction_q   <= RST_FRACTION;
			y_fraction_q   <= RST_FRACTION;
			x_scale_q      <= RST_SCALE;
			y_scale_q      <= RST_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_RESOLUTION: x_resolution_q <= cfg_data[RES_W-1:0];
				REG_SAMPLES_X:    samples_x_q    <= cfg_data[COUNT_W-1:0];
				REG_SAMPLES_Y:    samples_y_q    <= cfg_data[COUNT_W-1:0];
				REG_X_FRACTION:   x_fraction_q   <= cfg_data[FRAC_W-1:0];
				REG_Y_FRACTION:   y_fraction_q   <= cfg_data[FRAC_W-1:0];
				REG_X_SCALE:      x_scale_q      <= cfg_data[SCALE_W-1:0];
				REG_Y_SCALE:      y_scale_q      <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rgsg_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.x_resolution (x_resolution_q),
		.item_valid   (item_valid),
		.item_pop     (item_pop),
		.item_px      (item_px),
		.item_py      (item_py),
		.item_pid     (item_pid)
	);

	rgsg_back #(
		.COORD_BITS    (COORD_BITS),
		.MAX_GRID_SIDE (MAX_GRID_SIDE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_pop      (item_pop),
		.item_px       (item_px),
		.item_py       (item_py),
		.item_pid      (item_pid),
		.samples_x     (samples_x_q),
		.samples_y     (samples_y_q),
		.x_fraction    (x_fraction_q),
		.y_fraction    (y_fraction_q),
		.x_scale       (x_scale_q),
		.y_scale       (y_scale_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.screen_x      (screen_x),
		.screen_y      (screen_y),
		.sample_number (sample_number),
		.pixel_index   (pixel_index),
		.last_sample   (last_sample)
	);

endmodule

// ===== rtl/rgsg_checker.sv =====
// Port-level assertions for the regular grid sample generator and their binding.
module rgsg_checker import rgsg_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [POS_W-1:0] screen_x,
	input logic signed [POS_W-1:0] screen_y,
	input logic [SIDX_W-1:0]       sample_number,
	input logic [PIDX_W-1:0]       pixel_index,
	input logic                    last_sample
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(screen_y)
			&& $stable(sample_number) && $stable(pixel_index) && $stable(last_sample))
		else $error("Stalled output transaction changed.");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_sample |=> out_valid)
		else $error("Gap inside the samples of one pixel.");

	a_same_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_sample |=> pixel_index == $past(pixel_index))
		else $error("Pixel index changed before the last sample.");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_sample |=>
			sample_number == $past(sample_number) + SIDX_W'(1))
		else $error("Sample index did not advance by one.");

endmodule

bind regular_grid_sample_generator_top rgsg_checker u_rgsg_checker (.*);
